// File: rtl/core/ismu_pkg.sv
// ismu_pkg: shared types, codes and helpers for the ising metropolis spin update block
// used by ismu_wrap_reduce and ising_metropolis_spin_update; no dependencies
package ismu_pkg;

  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int THR_W      = 17;
  localparam int THR_WORD_W = 51;
  localparam int CHANCE_W   = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 51;
  localparam int K_W        = 4;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_D = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                spin_value;
    logic [CHANCE_W-1:0] chance;
  } in_item_t;

  typedef struct packed {
    logic spin;
    logic flipped;
  } out_item_t;

  // request and response of the shared remainder unit
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] value;
    logic [DIM_W-1:0]   modulus;
  } red_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] result;
  } red_rsp_t;

  // picks acceptance threshold k out of the four packed config words
  function automatic logic [THR_W-1:0] thr_pick(
    input logic [THR_WORD_W-1:0] word_a,
    input logic [THR_WORD_W-1:0] word_b,
    input logic [THR_WORD_W-1:0] word_c,
    input logic [THR_W-1:0]      word_d,
    input logic [K_W-1:0]        k
  );
    logic [THR_W-1:0] thr;
    unique case (k)
      4'd0:    thr = word_a[THR_W-1:0];
      4'd1:    thr = word_a[2*THR_W-1:THR_W];
      4'd2:    thr = word_a[3*THR_W-1:2*THR_W];
      4'd3:    thr = word_b[THR_W-1:0];
      4'd4:    thr = word_b[2*THR_W-1:THR_W];
      4'd5:    thr = word_b[3*THR_W-1:2*THR_W];
      4'd6:    thr = word_c[THR_W-1:0];
      4'd7:    thr = word_c[2*THR_W-1:THR_W];
      4'd8:    thr = word_c[3*THR_W-1:2*THR_W];
      default: thr = word_d;
    endcase
    return thr;
  endfunction

endpackage

// File: rtl/core/ismu_wrap_reduce.sv
// ismu_wrap_reduce: bit-serial remainder of an 8-bit coordinate by the grid dimension
// one restoring compare/subtract step per cycle; depends on ismu_pkg
module ismu_wrap_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  ismu_pkg::red_req_t req,
  output ismu_pkg::red_rsp_t rsp
);

  localparam int REM_W = ismu_pkg::DIM_W + 1;
  localparam int CNT_W = $clog2(ismu_pkg::COORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ismu_pkg::COORD_W - 1);

  logic                        run_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [ismu_pkg::COORD_W-1:0] val_r;
  logic [ismu_pkg::DIM_W-1:0]  mod_r;
  logic [ismu_pkg::DIM_W-1:0]  rem_r;
  logic [REM_W-1:0]            trial;
  logic [REM_W-1:0]            rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, val_r[ismu_pkg::COORD_W-1]};
    if (trial >= {1'b0, mod_r}) begin
      rem_nxt = trial - {1'b0, mod_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val_r <= req.value;
      mod_r <= req.modulus;
      rem_r <= '0;
    end else if (run_r) begin
      val_r <= {val_r[ismu_pkg::COORD_W-2:0], 1'b0};
      rem_r <= rem_nxt[ismu_pkg::DIM_W-1:0];
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = rem_r;

endmodule

// File: rtl/core/ising_metropolis_spin_update.sv
// ising_metropolis_spin_update: toroidal spin grid with load, read and metropolis update
// depends on ismu_pkg and ismu_wrap_reduce
//
//  channel  ports                          handshake
//  -------  -----------------------------  ---------------------------------------
//  input    start, busy, in_data           taken when start is high and busy is low
//  result   out_valid, out_data            one cycle strobe, always taken
//  config   cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// a coordinate at or above its dimension is first reduced in the shared bit-serial
// remainder unit. the single read port of the spin memory sets the update time: site
// and four neighbors one per cycle, then write-back. reset clears control and the
// thresholds and sets both dimensions to 256; spin memory contents are left as they are.
// the result cannot be stalled, and busy drops as the result register is loaded.
module ising_metropolis_spin_update #(
  parameter int MAX_ROWS = ismu_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ismu_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ismu_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output ismu_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ismu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ismu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int XRW   = ((RW > ismu_pkg::DIM_W) ? RW : ismu_pkg::DIM_W) + 1;
  localparam int XCW   = ((CW > ismu_pkg::DIM_W) ? CW : ismu_pkg::DIM_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHK_R  = 3'd1;
  localparam logic [2:0] S_WAIT_R = 3'd2;
  localparam logic [2:0] S_CHK_C  = 3'd3;
  localparam logic [2:0] S_WAIT_C = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_DEC    = 3'd6;

  // read slots of an update
  localparam logic [2:0] RD_SITE = 3'd0;
  localparam logic [2:0] RD_RP   = 3'd1;
  localparam logic [2:0] RD_RM   = 3'd2;
  localparam logic [2:0] RD_CP   = 3'd3;
  localparam logic [2:0] RD_CM   = 3'd4;

  logic [2:0]                          state_r, state_nxt;
  ismu_pkg::in_item_t                  item_r;
  logic [RW-1:0]                       r_r, r_nxt;
  logic [CW-1:0]                       c_r, c_nxt;
  logic [2:0]                          rd_cnt_r, rd_cnt_nxt;
  logic                                rd_vld_r;
  logic [2:0]                          rd_tag_r;
  logic                                mem_q_r;
  logic                                site_r;
  logic [2:0]                          ups_r;
  logic                                out_valid_r, out_valid_nxt;
  ismu_pkg::out_item_t                 out_r, out_nxt;

  logic [ismu_pkg::DIM_W-1:0]          rows_r, cols_r;
  logic [ismu_pkg::THR_WORD_W-1:0]     thr_a_r, thr_b_r, thr_c_r;
  logic [ismu_pkg::THR_W-1:0]          thr_d_r;

  logic                                spin_mem [DEPTH];

  logic                                accept;
  logic [ismu_pkg::DIM_W-1:0]          nr, nc;
  logic                                row_ok, col_ok;
  logic                                is_load, is_upd;
  logic [2:0]                          rd_last;
  logic [XRW-1:0]                      r_x, nr_x, r_inc;
  logic [XCW-1:0]                      c_x, nc_x, c_inc;
  logic [RW-1:0]                       rp, rm, ra_row;
  logic [CW-1:0]                       cp, cm, ra_col;
  logic [AW-1:0]                       raddr, waddr;
  logic                                mem_re, mem_we, mem_wd;
  logic [2:0]                          ups_all;
  logic [ismu_pkg::K_W-1:0]            k;
  logic [ismu_pkg::THR_W-1:0]          thr;
  logic                                flip;
  ismu_pkg::red_req_t                  red_req;
  ismu_pkg::red_rsp_t                  red_rsp;

  ismu_wrap_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .rsp   (red_rsp)
  );

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign is_load = (item_r.opcode == ismu_pkg::OP_LOAD);
  assign is_upd  = (item_r.opcode == ismu_pkg::OP_UPDATE);
  assign rd_last = is_upd ? RD_CM : RD_SITE;

  // effective dimensions, saturated to 1..MAX
  always_comb begin
    if (rows_r == '0) begin
      nr = ismu_pkg::DIM_W'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      nr = ismu_pkg::DIM_W'(MAX_ROWS);
    end else begin
      nr = rows_r;
    end
    if (cols_r == '0) begin
      nc = ismu_pkg::DIM_W'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      nc = ismu_pkg::DIM_W'(MAX_COLS);
    end else begin
      nc = cols_r;
    end
  end

  assign row_ok = (ismu_pkg::DIM_W'(item_r.row) < nr);
  assign col_ok = (ismu_pkg::DIM_W'(item_r.col) < nc);

  // wrapped neighbor coordinates
  assign r_x   = XRW'(r_r);
  assign nr_x  = XRW'(nr);
  assign r_inc = r_x + XRW'(1);
  assign rp    = (r_inc == nr_x) ? '0 : RW'(r_inc);
  assign rm    = (r_r == '0) ? RW'(nr_x - XRW'(1)) : r_r - RW'(1);
  assign c_x   = XCW'(c_r);
  assign nc_x  = XCW'(nc);
  assign c_inc = c_x + XCW'(1);
  assign cp    = (c_inc == nc_x) ? '0 : CW'(c_inc);
  assign cm    = (c_r == '0) ? CW'(nc_x - XCW'(1)) : c_r - CW'(1);

  always_comb begin
    ra_row = r_r;
    ra_col = c_r;
    case (rd_cnt_r)
      RD_RP:   ra_row = rp;
      RD_RM:   ra_row = rm;
      RD_CP:   ra_col = cp;
      RD_CM:   ra_col = cm;
      default: begin
        ra_row = r_r;
        ra_col = c_r;
      end
    endcase
  end

  assign raddr  = {ra_row, ra_col};
  assign waddr  = {r_r, c_r};
  assign mem_re = (state_r == S_RD);

  // decision, valid in S_DEC with the last read in mem_q_r
  assign ups_all = ups_r + 3'(mem_q_r);
  assign k       = ismu_pkg::K_W'(ups_all) + (site_r ? 4'd0 : 4'd5);
  assign thr     = ismu_pkg::thr_pick(thr_a_r, thr_b_r, thr_c_r, thr_d_r, k);
  assign flip    = ({1'b0, item_r.chance} < thr);

  always_comb begin
    state_nxt         = state_r;
    r_nxt             = r_r;
    c_nxt             = c_r;
    rd_cnt_nxt        = rd_cnt_r;
    out_valid_nxt     = 1'b0;
    out_nxt           = out_r;
    mem_we            = 1'b0;
    mem_wd            = item_r.spin_value;
    red_req.start     = 1'b0;
    red_req.value     = item_r.row;
    red_req.modulus   = nr;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_CHK_R;
          rd_cnt_nxt = RD_SITE;
        end
      end
      S_CHK_R: begin
        if (row_ok) begin
          r_nxt     = RW'(item_r.row);
          state_nxt = S_CHK_C;
        end else begin
          red_req.start = 1'b1;
          state_nxt     = S_WAIT_R;
        end
      end
      S_WAIT_R: begin
        if (red_rsp.done) begin
          r_nxt     = RW'(red_rsp.result);
          state_nxt = S_CHK_C;
        end
      end
      S_CHK_C: begin
        red_req.value   = item_r.col;
        red_req.modulus = nc;
        if (col_ok) begin
          c_nxt     = CW'(item_r.col);
          state_nxt = is_load ? S_DEC : S_RD;
        end else begin
          red_req.start = 1'b1;
          state_nxt     = S_WAIT_C;
        end
      end
      S_WAIT_C: begin
        red_req.value   = item_r.col;
        red_req.modulus = nc;
        if (red_rsp.done) begin
          c_nxt     = CW'(red_rsp.result);
          state_nxt = is_load ? S_DEC : S_RD;
        end
      end
      S_RD: begin
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == rd_last) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (is_load) begin
          mem_we          = 1'b1;
          out_nxt.spin    = item_r.spin_value;
          out_nxt.flipped = 1'b0;
        end else if (is_upd) begin
          mem_we          = flip;
          mem_wd          = ~site_r;
          out_nxt.spin    = site_r ^ flip;
          out_nxt.flipped = flip;
        end else begin
          out_nxt.spin    = mem_q_r;
          out_nxt.flipped = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= mem_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    rd_cnt_r <= rd_cnt_nxt;
    rd_tag_r <= rd_cnt_r;
    out_r    <= out_nxt;
  end

  // collect site and neighbor bits as reads come back
  always_ff @(posedge clk) begin
    if (accept) begin
      ups_r <= '0;
    end else if (rd_vld_r) begin
      if (rd_tag_r == RD_SITE) begin
        site_r <= mem_q_r;
      end else begin
        ups_r <= ups_r + 3'(mem_q_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= spin_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      spin_mem[waddr] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ismu_pkg::DIM_RESET;
      cols_r  <= ismu_pkg::DIM_RESET;
      thr_a_r <= '0;
      thr_b_r <= '0;
      thr_c_r <= '0;
      thr_d_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ismu_pkg::REG_ROWS:  rows_r  <= cfg_data[ismu_pkg::DIM_W-1:0];
        ismu_pkg::REG_COLS:  cols_r  <= cfg_data[ismu_pkg::DIM_W-1:0];
        ismu_pkg::REG_THR_A: thr_a_r <= cfg_data[ismu_pkg::THR_WORD_W-1:0];
        ismu_pkg::REG_THR_B: thr_b_r <= cfg_data[ismu_pkg::THR_WORD_W-1:0];
        ismu_pkg::REG_THR_C: thr_c_r <= cfg_data[ismu_pkg::THR_WORD_W-1:0];
        ismu_pkg::REG_THR_D: thr_d_r <= cfg_data[ismu_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_out_after_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_DEC)
    else $error("result strobe without a decision cycle");

  a_flip_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.flipped) |-> (item_r.opcode == ismu_pkg::OP_UPDATE))
    else $error("flip reported for a load or read transaction");

  a_coord_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((r_x < nr_x) && (c_x < nc_x)))
    else $error("site coordinate not reduced below grid dimension");
`endif

endmodule

// File: test/ising_metropolis_spin_update_test.sv
// ising_metropolis_spin_update_test: self-checking testbench for the toroidal spin grid
// drives load, read and metropolis update commands, predicts each result; needs ismu_pkg
module ising_metropolis_spin_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ismu_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, behaves as a read
  localparam int GRID_SITES = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {DIR_SELF, DIR_NEXT_ROW, DIR_PREV_ROW, DIR_NEXT_COL, DIR_PREV_COL} nbr_dir_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the block: grid contents, which sites hold a known spin, registers
  bit                    spin_site   [GRID_SITES];
  bit                    site_loaded [GRID_SITES];
  logic [DIM_W-1:0]      rows_reg = DIM_RESET;
  logic [DIM_W-1:0]      cols_reg = DIM_RESET;
  logic [THR_WORD_W-1:0] thr_a = '0;
  logic [THR_WORD_W-1:0] thr_b = '0;
  logic [THR_WORD_W-1:0] thr_c = '0;
  logic [THR_W-1:0]      thr_d = '0;

  out_item_t expected_spins[$];
  int        mismatches = 0;
  bit        gaps_on = 1'b1;

  ising_metropolis_spin_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: %s: got %b, expected %b", $time, what, got, want);
    end
  endtask

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
    if (v == 0) return 1;
    if (v > max_dim) return max_dim;
    return int'(v);
  endfunction

  // grid address of the site or one of its four wrapped neighbors
  function automatic int nbr_site(input int r, input int c, input int nr, input int nc,
                                  input nbr_dir_t dir);
    int rr;
    int cc;
    rr = r;
    cc = c;
    case (dir)
      DIR_NEXT_ROW: rr = (r + 1 == nr) ? 0 : r + 1;
      DIR_PREV_ROW: rr = (r == 0) ? nr - 1 : r - 1;
      DIR_NEXT_COL: cc = (c + 1 == nc) ? 0 : c + 1;
      DIR_PREV_COL: cc = (c == 0) ? nc - 1 : c - 1;
      default: ;
    endcase
    return rr * MAX_COLS_DEF + cc;
  endfunction

  function automatic logic [THR_W-1:0] thr_entry(input int k);
    logic [THR_WORD_W-1:0] word;
    if (k == 9) return thr_d;
    word = (k < 3) ? thr_a : (k < 6) ? thr_b : thr_c;
    return word[THR_W*(k%3) +: THR_W];
  endfunction

  // updates the shadow grid and returns the result the block must give
  function automatic out_item_t apply_spin_op(input in_item_t op);
    out_item_t res;
    int nr;
    int nc;
    int r;
    int c;
    int a;
    int ups;
    int k;
    nr = eff_dim(rows_reg, MAX_ROWS_DEF);
    nc = eff_dim(cols_reg, MAX_COLS_DEF);
    r = op.row % nr;
    c = op.col % nc;
    a = nbr_site(r, c, nr, nc, DIR_SELF);
    res.flipped = 1'b0;
    if (op.opcode == OP_LOAD) begin
      spin_site[a] = op.spin_value;
      site_loaded[a] = 1'b1;
    end else if (op.opcode == OP_UPDATE) begin
      ups = int'(spin_site[nbr_site(r, c, nr, nc, DIR_NEXT_ROW)])
          + int'(spin_site[nbr_site(r, c, nr, nc, DIR_PREV_ROW)])
          + int'(spin_site[nbr_site(r, c, nr, nc, DIR_NEXT_COL)])
          + int'(spin_site[nbr_site(r, c, nr, nc, DIR_PREV_COL)]);
      k = ups + (spin_site[a] ? 0 : 5);
      if (op.chance < thr_entry(k)) begin
        spin_site[a] = ~spin_site[a];
        res.flipped = 1'b1;
      end
    end
    res.spin = spin_site[a];
    return res;
  endfunction

  // address of a site the command would touch before it was ever loaded, else -1
  function automatic int first_unloaded(input in_item_t op);
    int nr;
    int nc;
    int r;
    int c;
    int a;
    int d;
    if (op.opcode == OP_LOAD) return -1;
    nr = eff_dim(rows_reg, MAX_ROWS_DEF);
    nc = eff_dim(cols_reg, MAX_COLS_DEF);
    r = op.row % nr;
    c = op.col % nc;
    for (d = 0; d <= ((op.opcode == OP_UPDATE) ? 4 : 0); d++) begin
      a = nbr_site(r, c, nr, nc, nbr_dir_t'(d));
      if (!site_loaded[a]) return a;
    end
    return -1;
  endfunction

  function automatic in_item_t make_op(input logic [OP_W-1:0] opcode, input int row,
                                       input int col, input logic spin, input int chance);
    in_item_t op;
    op.opcode = opcode;
    op.row = COORD_W'(row);
    op.col = COORD_W'(col);
    op.spin_value = spin;
    op.chance = CHANCE_W'(chance);
    return op;
  endfunction

  // mostly near the wrap corner on big grids so updates find loaded neighbors
  function automatic logic [COORD_W-1:0] raw_coord(input int dim);
    int red;
    int wraps;
    if ($urandom_range(9) == 0) return COORD_W'($urandom_range(255));
    if (dim > 16) red = (dim - 3 + $urandom_range(4)) % dim;
    else red = $urandom_range(dim - 1);
    wraps = (255 - red) / dim;
    return COORD_W'(red + dim * $urandom_range(wraps));
  endfunction

  function automatic in_item_t rand_spin_op();
    in_item_t op;
    int pick;
    int miss;
    pick = $urandom_range(99);
    if (pick < 50) op.opcode = OP_UPDATE;
    else if (pick < 68) op.opcode = OP_LOAD;
    else if (pick < 90) op.opcode = OP_READ;
    else op.opcode = OP_SPARE;
    op.row = raw_coord(eff_dim(rows_reg, MAX_ROWS_DEF));
    op.col = raw_coord(eff_dim(cols_reg, MAX_COLS_DEF));
    op.spin_value = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: op.chance = '0;
      1: op.chance = '1;
      default: op.chance = CHANCE_W'($urandom_range(16'hFFFF));
    endcase
    // fill in a missing site first instead of touching unknown contents
    miss = first_unloaded(op);
    if (miss >= 0) begin
      op.opcode = OP_LOAD;
      op.row = COORD_W'(miss / MAX_COLS_DEF);
      op.col = COORD_W'(miss % MAX_COLS_DEF);
    end
    return op;
  endfunction

  function automatic logic [THR_W-1:0] rand_threshold();
    case ($urandom_range(5))
      0: return '0;
      1: return 17'h0FFFF;
      2: return 17'h10000;
      3: return '1;
      4: return THR_W'($urandom_range(16'hFFFF));
      default: return THR_W'($urandom);
    endcase
  endfunction

  task automatic issue_spin_op(input in_item_t op);
    if (gaps_on) begin
      while ($urandom_range(99) < 17) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (busy);
    expected_spins.push_back(apply_spin_op(op));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_spins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS:  rows_reg = val[DIM_W-1:0];
      REG_COLS:  cols_reg = val[DIM_W-1:0];
      REG_THR_A: thr_a = val[THR_WORD_W-1:0];
      REG_THR_B: thr_b = val[THR_WORD_W-1:0];
      REG_THR_C: thr_c = val[THR_WORD_W-1:0];
      REG_THR_D: thr_d = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input bit pick_random, input logic [THR_W-1:0] fill);
    logic [THR_W-1:0] e [10];
    int k;
    for (k = 0; k < 10; k++) e[k] = pick_random ? rand_threshold() : fill;
    write_reg(REG_THR_A, {e[2], e[1], e[0]});
    write_reg(REG_THR_B, {e[5], e[4], e[3]});
    write_reg(REG_THR_C, {e[8], e[7], e[6]});
    write_reg(REG_THR_D, CFG_DATA_W'(e[9]));
  endtask

  task automatic set_dims(input int rows, input int cols);
    write_reg(REG_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_COLS, CFG_DATA_W'(cols));
  endtask

  // reset values: full 256 x 256 torus, all thresholds zero so nothing flips
  task automatic test_reset_state();
    issue_spin_op(make_op(OP_LOAD, 0, 0, 1'b1, 0));
    issue_spin_op(make_op(OP_LOAD, 1, 0, 1'b0, 16'hFFFF));
    issue_spin_op(make_op(OP_LOAD, 255, 0, 1'b1, 0));
    issue_spin_op(make_op(OP_LOAD, 0, 1, 1'b1, 0));
    issue_spin_op(make_op(OP_LOAD, 0, 255, 1'b0, 0));
    issue_spin_op(make_op(OP_UPDATE, 0, 0, 1'b0, 0));
    issue_spin_op(make_op(OP_READ, 0, 0, 1'b1, 0));
    issue_spin_op(make_op(OP_SPARE, 0, 255, 1'b1, 16'hFFFF));
  endtask

  // thresholds at their maximum and around 2^16 against the top chance values
  task automatic test_threshold_extremes();
    wait_idle();
    set_thresholds(1'b0, '1);
    issue_spin_op(make_op(OP_UPDATE, 0, 0, 1'b0, 16'hFFFF));
    wait_idle();
    set_thresholds(1'b0, 17'h10000);
    issue_spin_op(make_op(OP_UPDATE, 0, 0, 1'b0, 16'hFFFF));
    wait_idle();
    set_thresholds(1'b0, 17'h0FFFF);
    issue_spin_op(make_op(OP_UPDATE, 0, 0, 1'b0, 16'hFFFF));
    issue_spin_op(make_op(OP_UPDATE, 0, 0, 1'b0, 16'hFFFE));
  endtask

  // one-site torus, zero dimensions and dimensions above the grid size
  task automatic test_degenerate_dims();
    wait_idle();
    set_dims(1, 1);
    issue_spin_op(make_op(OP_UPDATE, 255, 255, 1'b0, 0));
    issue_spin_op(make_op(OP_READ, 7, 200, 1'b0, 0));
    wait_idle();
    set_dims(0, 0);
    issue_spin_op(make_op(OP_SPARE, 3, 3, 1'b0, 0));
    wait_idle();
    set_dims(511, 300);
    issue_spin_op(make_op(OP_READ, 255, 0, 1'b0, 0));
    issue_spin_op(make_op(OP_LOAD, 255, 255, 1'b1, 0));
    issue_spin_op(make_op(OP_UPDATE, 0, 0, 1'b1, 16'h8000));
  endtask

  task automatic test_random_phases();
    int phase_rows [9] = '{8, 1, 16, 2, 0, 256, 200, 511, 5};
    int phase_cols [9] = '{8, 16, 1, 3, 5, 256, 37, 3, 9};
    int p;
    int n;
    for (p = 0; p < 9; p++) begin
      wait_idle();
      set_dims(phase_rows[p], phase_cols[p]);
      set_thresholds(1'b1, '0);
      gaps_on = (p != 2);  // one phase runs back to back
      for (n = 0; n < ITEMS_PER_PHASE; n++) issue_spin_op(rand_spin_op());
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_spins.size() == 0) begin
        report_mismatch("result with no transaction pending", out_data.spin, 1'b0);
      end else begin
        want = expected_spins.pop_front();
        if (out_data.spin !== want.spin) report_mismatch("spin", out_data.spin, want.spin);
        if (out_data.flipped !== want.flipped) begin
          report_mismatch("flipped", out_data.flipped, want.flipped);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_threshold_extremes();
    test_degenerate_dims();
    test_random_phases();
    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
